[rtl/pqbu_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// pqbu_pkg
// Shared types, sizes and constant tables of the quadratic blend upsampler.
// ---------------------------------------------------------------------------
package pqbu_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int POS_W      = 16;
   localparam int CNT_W      = 13;
   localparam int DEG_W      = 5;
   localparam int MAX_POINTS = 4096;
   localparam int MAX_DEGREE = 16;
   localparam int MAX_BURST  = 48;
   localparam int JOBQ_DEPTH = 8;
   localparam int JOBQ_AW    = $clog2(JOBQ_DEPTH);
   localparam int JOBS_MAX   = 4;
   localparam int BQ_DEPTH   = 16;
   localparam int BQ_AW      = $clog2(BQ_DEPTH);
   localparam int BURST_W    = 6;
   localparam int STEP_NUM   = 65536;

   // csr register indexes
   localparam logic CSR_POINT_COUNT     = 1'b0;
   localparam logic CSR_UPSAMPLE_DEGREE = 1'b1;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   // one interval to expand: four neighbors, base position, degree
   typedef struct packed {
      sample_type             ym;
      sample_type             y0;
      sample_type             y1;
      sample_type             y2;
      logic [POS_W-1:0]       base;
      logic [DEG_W-1:0]       deg;
   } job_type;

   typedef struct packed {
      logic                   avail;
      logic                   room;
   } jobq_status_type;

   typedef struct packed {
      logic                   valid;
      logic [BURST_W-1:0]     size;
   } burst_push_type;

   typedef enum logic {FRONT_IDLE, FRONT_GEN} front_state_type;
   typedef enum logic {BACK_IDLE, BACK_RUN} back_state_type;

   // 65536 = STEP_QUOT[d-1]*d + STEP_REM[d-1]; walks round(j*65536/d) one j at a time
   localparam logic [16:0] STEP_QUOT [MAX_DEGREE] = '{
      17'(STEP_NUM / 1),  17'(STEP_NUM / 2),  17'(STEP_NUM / 3),  17'(STEP_NUM / 4),
      17'(STEP_NUM / 5),  17'(STEP_NUM / 6),  17'(STEP_NUM / 7),  17'(STEP_NUM / 8),
      17'(STEP_NUM / 9),  17'(STEP_NUM / 10), 17'(STEP_NUM / 11), 17'(STEP_NUM / 12),
      17'(STEP_NUM / 13), 17'(STEP_NUM / 14), 17'(STEP_NUM / 15), 17'(STEP_NUM / 16)};
   localparam logic [DEG_W-1:0] STEP_REM [MAX_DEGREE] = '{
      5'(STEP_NUM % 1),  5'(STEP_NUM % 2),  5'(STEP_NUM % 3),  5'(STEP_NUM % 4),
      5'(STEP_NUM % 5),  5'(STEP_NUM % 6),  5'(STEP_NUM % 7),  5'(STEP_NUM % 8),
      5'(STEP_NUM % 9),  5'(STEP_NUM % 10), 5'(STEP_NUM % 11), 5'(STEP_NUM % 12),
      5'(STEP_NUM % 13), 5'(STEP_NUM % 14), 5'(STEP_NUM % 15), 5'(STEP_NUM % 16)};

endpackage
`default_nettype wire

[rtl/pqbu_ifs.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// pqbu_ifs
// Valid/ready channel interfaces for sample and result words.
// ---------------------------------------------------------------------------
interface pqbu_req_if import pqbu_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_value;
   logic                       row_last;
   modport source (output valid, output sample_value, output row_last, input ready);
   modport sink   (input valid, input sample_value, input row_last, output ready);
endinterface

interface pqbu_rsp_if import pqbu_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] interp_value;
   logic [POS_W-1:0]           out_position;
   logic                       burst_last;
   modport source (output valid, output interp_value, output out_position,
                   output burst_last, input ready);
   modport sink   (input valid, input interp_value, input out_position,
                   input burst_last, output ready);
endinterface
`default_nettype wire

[rtl/pqbu_front.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// pqbu_front
// Takes samples, keeps row history, sizes bursts and issues interval jobs.
// ---------------------------------------------------------------------------
module pqbu_front import pqbu_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [CNT_W-1:0]  point_count,
   input  wire logic [DEG_W-1:0]  upsample_degree,
   pqbu_req_if.sink               req,
   input  wire jobq_status_type   jobq_status,
   input  wire logic              burst_room,
   output logic                   job_push,
   output job_type                job_out,
   output burst_push_type         burst_push
);

   front_state_type  state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   sample_type       head_ff [3];
   sample_type       win_ff [4];
   logic [6:0]       backlog_ff, backlog_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [CNT_W-1:0] m_ff, m_in;
   logic [2:0]       left_ff, left_in;
   logic             lastrow_ff, lastrow_in;
   logic [DEG_W-1:0] deg_ff, deg_in;

   logic [CNT_W-1:0] limit;
   logic [DEG_W-1:0] deg_eff;
   logic             accept, row_end;
   logic [CNT_W:0]   k_next;
   logic [2:0]       new_jobs;
   logic [7:0]       total;
   logic [BURST_W-1:0] burst;
   logic [CNT_W-1:0] m_cur, im1, i1;
   logic [CNT_W:0]   i1w, i2w;
   logic [CNT_W-1:0] i2;
   logic [17:0]      base_full;

   function automatic sample_type pick(input logic [CNT_W-1:0] x, input logic [CNT_W-1:0] n,
                                       input sample_type hd [3], input sample_type wn [4]);
      logic [CNT_W-1:0] back;
      back = n - 13'd1 - x;
      if (x < 13'd3) return hd[x[1:0]];
      return wn[back[1:0]];
   endfunction

   always_comb begin
      limit   = (point_count == '0 || point_count > 13'(MAX_POINTS)) ? 13'(MAX_POINTS)
                                                                    : point_count;
      deg_eff = (upsample_degree == '0) ? 5'd1 :
                (upsample_degree > 5'(MAX_DEGREE)) ? 5'(MAX_DEGREE) : upsample_degree;
      req.ready = (state_ff == FRONT_IDLE) && jobq_status.room && burst_room;
      accept  = req.valid && req.ready;
      k_next  = {1'b0, cnt_ff} + 14'd1;
      row_end = req.row_last || (k_next >= {1'b0, limit});
      if (row_end)
         new_jobs = (k_next >= 14'd4) ? 3'd4 : 3'(k_next);
      else
         new_jobs = (cnt_ff >= 13'd3) ? 3'd1 : 3'd0;
      total = 8'(backlog_ff) + 8'(8'(new_jobs) * 8'(deg_eff));
      burst = (total > 8'(MAX_BURST)) ? 6'(MAX_BURST) : 6'(total);
      backlog_in = 7'(total - 8'(burst));
      burst_push.valid = accept && (burst != '0);
      burst_push.size  = burst;

      // interval list of the word just taken
      m_cur = (lastrow_ff && left_ff == 3'd1) ? '0 : m_ff;
      im1   = (m_cur == '0) ? n_ff - 13'd1 : m_cur - 13'd1;
      i1w   = {1'b0, m_cur} + 14'd1;
      if (i1w >= {1'b0, n_ff}) i1w = i1w - {1'b0, n_ff};
      i1    = 13'(i1w);
      i2w   = {1'b0, m_cur} + 14'd2;
      if (i2w >= {1'b0, n_ff}) i2w = i2w - {1'b0, n_ff};
      if (i2w >= {1'b0, n_ff}) i2w = i2w - {1'b0, n_ff};
      i2    = 13'(i2w);
      base_full = 18'(m_cur) * 18'(deg_ff);
      job_out.ym   = pick(im1, n_ff, head_ff, win_ff);
      job_out.y0   = pick(m_cur, n_ff, head_ff, win_ff);
      job_out.y1   = pick(i1, n_ff, head_ff, win_ff);
      job_out.y2   = pick(i2, n_ff, head_ff, win_ff);
      job_out.base = base_full[POS_W-1:0];
      job_out.deg  = deg_ff;
      job_push     = (state_ff == FRONT_GEN);

      state_in   = state_ff;
      cnt_in     = cnt_ff;
      n_in       = n_ff;
      m_in       = m_ff;
      left_in    = left_ff;
      lastrow_in = lastrow_ff;
      deg_in     = deg_ff;
      unique case (state_ff)
         FRONT_IDLE: begin
            if (accept) begin
               cnt_in     = row_end ? '0 : 13'(k_next);
               n_in       = 13'(k_next);
               lastrow_in = row_end;
               deg_in     = deg_eff;
               left_in    = new_jobs;
               if (row_end)
                  m_in = (k_next >= 14'd4) ? 13'(k_next - 14'd3) : 13'd1;
               else
                  m_in = cnt_ff - 13'd2;
               if (new_jobs != '0) state_in = FRONT_GEN;
            end
         end
         FRONT_GEN: begin
            m_in    = m_ff + 13'd1;
            left_in = left_ff - 3'd1;
            if (left_ff == 3'd1) state_in = FRONT_IDLE;
         end
         default: state_in = FRONT_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= FRONT_IDLE;
         cnt_ff     <= '0;
         backlog_ff <= '0;
         left_ff    <= '0;
         lastrow_ff <= 1'b0;
         head_ff    <= '{default: '0};
         win_ff     <= '{default: '0};
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         left_ff    <= left_in;
         lastrow_ff <= lastrow_in;
         if (accept) begin
            backlog_ff <= backlog_in;
            if (cnt_ff < 13'd3) head_ff[cnt_ff[1:0]] <= req.sample_value;
            win_ff[3] <= win_ff[2];
            win_ff[2] <= win_ff[1];
            win_ff[1] <= win_ff[0];
            win_ff[0] <= req.sample_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      m_ff   <= m_in;
      deg_ff <= deg_in;
   end

endmodule
`default_nettype wire

[rtl/pqbu_job_queue.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// pqbu_job_queue
// Short FIFO of interval jobs between front and back.
// ---------------------------------------------------------------------------
module pqbu_job_queue import pqbu_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire job_type     job_in,
   input  wire logic        pop,
   output job_type          job_head,
   output jobq_status_type  status
);

   job_type            mem_ff [JOBQ_DEPTH];
   logic [JOBQ_AW-1:0] wr_ff, rd_ff;
   logic [JOBQ_AW:0]   count_ff;

   assign job_head     = mem_ff[rd_ff];
   assign status.avail = (count_ff != '0);
   // room for a full set of jobs from one word
   assign status.room  = (count_ff <= (JOBQ_AW+1)'(JOBQ_DEPTH - JOBS_MAX));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         count_ff <= count_ff + (JOBQ_AW+1)'(push) - (JOBQ_AW+1)'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= job_in;
   end

endmodule
`default_nettype wire

[rtl/pqbu_back.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// pqbu_back
// Walks each job through the blend pipeline one point a clock unless stalled; marks bursts.
// ---------------------------------------------------------------------------
module pqbu_back import pqbu_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire job_type         job_head,
   input  wire jobq_status_type jobq_status,
   output logic                 job_pop,
   input  wire burst_push_type  burst_push,
   output logic                 burst_room,
   pqbu_rsp_if.source           rsp
);

   typedef struct packed {
      logic [15:0]        w;
      logic [16:0]        u;
      logic signed [16:0] c2;
      logic [POS_W-1:0]   pos;
      logic               last;
   } ctl_type;

   // sequencer
   back_state_type     state_ff, state_in;
   logic signed [19:0] al_ff, bl_ff, ar_ff, br_ff;
   logic signed [16:0] c2_ff;
   logic [POS_W-1:0]   base_ff;
   logic [DEG_W-1:0]   deg_ff;
   logic [3:0]         j_ff;
   logic [16:0]        q_ff;
   logic [DEG_W-1:0]   r_ff;
   logic [DEG_W:0]     r_sum;
   logic [3:0]         tab_idx;
   logic               load, en, issue, last_pt, burst_end;

   // burst size FIFO
   logic [BURST_W-1:0] bq_ff [BQ_DEPTH];
   logic [BQ_AW-1:0]   bq_wr_ff, bq_rd_ff;
   logic [BQ_AW:0]     bq_cnt_ff;
   logic [BURST_W-1:0] bcnt_ff;

   // pipeline
   logic               va_ff, vb_ff, vc_ff, vd_ff, ve_ff, vo_ff;
   ctl_type            ctl_i, ca_ff, cb_ff, cc_ff, cd_ff, ce_ff;
   logic signed [36:0] pl_ff, pr_ff;
   logic signed [19:0] bla_ff, bra_ff;
   logic signed [29:0] tl_ff, tr_ff;
   logic signed [46:0] ql_ff, qr_ff;
   logic signed [31:0] el_ff, er_ff;
   logic signed [49:0] ml_ff, mr_ff;
   logic signed [16:0] ws_i, wsb, wsd;
   logic signed [17:0] usd;
   logic signed [37:0] sl, sr;
   logic signed [47:0] dl, dr;
   logic signed [50:0] fsum;
   logic signed [25:0] rnd;
   logic signed [15:0] sat;
   logic signed [15:0] val_ff;
   logic [POS_W-1:0]   pos_ff;
   logic               last_ff;

   always_comb begin
      en        = !vo_ff || rsp.ready;
      last_pt   = ({1'b0, j_ff} + 5'd1 == deg_ff);
      issue     = en && (state_ff == BACK_RUN) && (bq_cnt_ff != '0);
      burst_end = ({1'b0, bcnt_ff} + 7'd1 == {1'b0, bq_ff[bq_rd_ff]});
      load      = jobq_status.avail && ((state_ff == BACK_IDLE) || (issue && last_pt));
      job_pop   = load;
      burst_room = (bq_cnt_ff < (BQ_AW+1)'(BQ_DEPTH));
      tab_idx   = 4'(deg_ff - 5'd1);
      r_sum     = {1'b0, r_ff} + {1'b0, STEP_REM[tab_idx]};

      state_in = state_ff;
      unique case (state_ff)
         BACK_IDLE: if (jobq_status.avail) state_in = BACK_RUN;
         BACK_RUN:  if (issue && last_pt && !jobq_status.avail) state_in = BACK_IDLE;
         default:   state_in = BACK_IDLE;
      endcase

      ctl_i.w    = q_ff[15:0];
      ctl_i.u    = 17'd65536 - {1'b0, q_ff[15:0]};
      ctl_i.c2   = c2_ff;
      ctl_i.pos  = base_ff + POS_W'(j_ff);
      ctl_i.last = burst_end;
      ws_i = $signed({1'b0, q_ff[15:0]});
      wsb  = $signed({1'b0, cb_ff.w});
      wsd  = $signed({1'b0, cd_ff.w});
      usd  = $signed({1'b0, cd_ff.u});

      // t1 = round(2a*W + 2b*2^16, Q8)
      sl = 38'(pl_ff) + (38'(bla_ff) <<< 16) + 38'sd128;
      sr = 38'(pr_ff) + (38'(bra_ff) <<< 16) + 38'sd128;
      // 2P = round(t1*W + 2c*2^24, Q8 result)
      dl = 48'(ql_ff) + (48'(cc_ff.c2) <<< 24) + 48'sd32768;
      dr = 48'(qr_ff) + (48'(cc_ff.c2) <<< 24) + 48'sd32768;
      // U*2L + W*2R in Q24
      fsum = 51'(ml_ff) + 51'(mr_ff) + 51'sd16777216;
      rnd  = 26'(fsum >>> 25);
      if (rnd > 26'sd32767)       sat = 16'sh7fff;
      else if (rnd < -26'sd32768) sat = 16'sh8000;
      else                        sat = 16'(rnd);
   end

   assign rsp.valid        = vo_ff;
   assign rsp.interp_value = val_ff;
   assign rsp.out_position = pos_ff;
   assign rsp.burst_last   = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BACK_IDLE;
         bq_wr_ff  <= '0;
         bq_rd_ff  <= '0;
         bq_cnt_ff <= '0;
         bcnt_ff   <= '0;
         va_ff <= 1'b0; vb_ff <= 1'b0; vc_ff <= 1'b0;
         vd_ff <= 1'b0; ve_ff <= 1'b0; vo_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (burst_push.valid) bq_wr_ff <= bq_wr_ff + 1'b1;
         if (issue && burst_end) begin
            bq_rd_ff <= bq_rd_ff + 1'b1;
            bcnt_ff  <= '0;
         end else if (issue) begin
            bcnt_ff  <= bcnt_ff + 6'd1;
         end
         bq_cnt_ff <= bq_cnt_ff + (BQ_AW+1)'(burst_push.valid)
                                - (BQ_AW+1)'(issue && burst_end);
         if (en) begin
            va_ff <= issue;
            vb_ff <= va_ff;
            vc_ff <= vb_ff;
            vd_ff <= vc_ff;
            ve_ff <= vd_ff;
            vo_ff <= ve_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (burst_push.valid) bq_ff[bq_wr_ff] <= burst_push.size;
      if (load) begin
         al_ff   <= 20'(job_head.ym) - (20'(job_head.y0) <<< 1) + 20'(job_head.y1);
         bl_ff   <= 20'(job_head.y1) - 20'(job_head.ym);
         ar_ff   <= 20'(job_head.y0) - (20'(job_head.y1) <<< 1) + 20'(job_head.y2);
         br_ff   <= (20'(job_head.y1) <<< 2) - 20'sd3 * 20'(job_head.y0)
                    - 20'(job_head.y2);
         c2_ff   <= 17'(job_head.y0) <<< 1;
         base_ff <= job_head.base;
         deg_ff  <= job_head.deg;
         j_ff    <= '0;
         q_ff    <= '0;
         r_ff    <= job_head.deg >> 1;
      end else if (issue) begin
         j_ff <= j_ff + 4'd1;
         if (r_sum >= {1'b0, deg_ff}) begin
            r_ff <= 5'(r_sum - {1'b0, deg_ff});
            q_ff <= q_ff + STEP_QUOT[tab_idx] + 17'd1;
         end else begin
            r_ff <= 5'(r_sum);
            q_ff <= q_ff + STEP_QUOT[tab_idx];
         end
      end
      if (en) begin
         pl_ff   <= al_ff * ws_i;
         pr_ff   <= ar_ff * ws_i;
         bla_ff  <= bl_ff;
         bra_ff  <= br_ff;
         ca_ff   <= ctl_i;
         tl_ff   <= 30'(sl >>> 8);
         tr_ff   <= 30'(sr >>> 8);
         cb_ff   <= ca_ff;
         ql_ff   <= tl_ff * wsb;
         qr_ff   <= tr_ff * wsb;
         cc_ff   <= cb_ff;
         el_ff   <= 32'(dl >>> 16);
         er_ff   <= 32'(dr >>> 16);
         cd_ff   <= cc_ff;
         ml_ff   <= usd * el_ff;
         mr_ff   <= wsd * er_ff;
         ce_ff   <= cd_ff;
         val_ff  <= sat;
         pos_ff  <= ce_ff.pos;
         last_ff <= ce_ff.last;
      end
   end

endmodule
`default_nettype wire

[rtl/periodic_quadratic_blend_upsampler.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// periodic_quadratic_blend_upsampler
// Integer-degree upsampler of one periodic row, blending two parabolas.
// ---------------------------------------------------------------------------
// Samples of a row enter one per word on req_chan; row_last or reaching
// point_count closes the row. For each interval the block emits degree points:
// a copy of the sample, then blends of a left and a right parabola at weights
// round(j/degree) in Q0.16, rounded half up and saturated to 16 bits. An
// interval comes out once sample i+2 is in; the closing sample flushes the
// wrapped intervals and interval 0 comes last. Each word's results form one
// burst of at most 48, flagged by burst_last on its final point; the excess
// leads the next word's burst. The front takes a word and writes its interval
// jobs (up to four) into the job queue one after another, taking no new word
// until they are written; the back issues one point per clock, unless the
// output stalls, into a six-stage multiply pipeline. csr writes (index 0
// point_count, index 1 upsample_degree) must be made while the block is idle;
// they apply from the next sample.
// ---------------------------------------------------------------------------
module periodic_quadratic_blend_upsampler import pqbu_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   pqbu_req_if.sink               req_chan,
   pqbu_rsp_if.source             rsp_chan,
   input  wire logic              csr_wr_en,
   input  wire logic              csr_index,
   input  wire logic [CNT_W-1:0]  csr_wr_data
);

   logic [CNT_W-1:0] point_count_ff;
   logic [DEG_W-1:0] degree_ff;

   jobq_status_type  jobq_status;
   job_type          job_in, job_head;
   logic             job_push, job_pop;
   burst_push_type   burst_push;
   logic             burst_room;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= 13'd64;
         degree_ff      <= 5'd2;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_POINT_COUNT:     point_count_ff <= csr_wr_data;
            CSR_UPSAMPLE_DEGREE: degree_ff      <= csr_wr_data[DEG_W-1:0];
            default: ;
         endcase
      end
   end

   // front: row history, burst sizing, interval jobs
   pqbu_front u_front (
      .clock           (clock),
      .reset           (reset),
      .point_count     (point_count_ff),
      .upsample_degree (degree_ff),
      .req             (req_chan),
      .jobq_status     (jobq_status),
      .burst_room      (burst_room),
      .job_push        (job_push),
      .job_out         (job_in),
      .burst_push      (burst_push)
   );

   // decouples job issue from point generation
   pqbu_job_queue u_job_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .job_in   (job_in),
      .pop      (job_pop),
      .job_head (job_head),
      .status   (jobq_status)
   );

   // back: point sequencer, blend pipeline, output register
   pqbu_back u_back (
      .clock       (clock),
      .reset       (reset),
      .job_head    (job_head),
      .jobq_status (jobq_status),
      .job_pop     (job_pop),
      .burst_push  (burst_push),
      .burst_room  (burst_room),
      .rsp         (rsp_chan)
   );

endmodule
`default_nettype wire
